FILE: design/gcdb_pkg.sv
// Package for the great-circle distance and bearing block.
// Holds shared widths, fixed-point constants, the CORDIC angle table and types.
// Depends on nothing; every other design file but gcdb_delay imports it.
package gcdb_pkg;

  // Default parameter values for the top level.
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 24;

  // Field widths.
  localparam int LAT_W      = 24;
  localparam int LON_W      = 25;
  localparam int CFG_W      = 25;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;
  localparam int DIST_W     = 19;
  localparam int BEAR_W     = 15;

  // Sine and cosine results are Q30 in a 32 bit signed word.
  localparam int SC_W = 32;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // Square root unit: Q60 operand, Q30 root, one result bit per step.
  localparam int A60_W      = 61;
  localparam int ROOT_W     = 31;
  localparam int SQRT_STEPS = 31;

  // Output scaling.
  localparam logic [31:0]       DIST_SCALE   = 32'd2623417457;
  localparam logic [BEAR_W-1:0] BEARING_FULL = 15'd23040;

  // Arctangent of 2^-i in binary angle units (2^32 per turn).
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_HOME_LAT = 1'b0,
    REG_HOME_LON = 1'b1
  } cfg_reg_t;

  // Per-item control flags that ride along the datapath.
  typedef struct packed {
    logic vld;
    logic pos;
    logic same;
  } flags_t;

  // One result item.
  typedef struct packed {
    logic              distance_valid;
    logic [DIST_W-1:0] distance;
    logic [BEAR_W-1:0] bearing;
  } result_t;

endpackage

FILE: design/gcdb_delay.sv
// Enabled shift line that delays a word by a fixed number of pipeline steps.
// Used to keep flags and the bearing vector in step with the datapath.
// Depends on nothing outside this file.
module gcdb_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [WIDTH-1:0] d_in,
  output logic [WIDTH-1:0] d_out
);

  logic [WIDTH-1:0] line_r [DEPTH];

  // Shift one place on every enabled cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) line_r[i] <= '0;
    end else if (en) begin
      line_r[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) line_r[i] <= line_r[i-1];
    end
  end

  assign d_out = line_r[DEPTH-1];

endmodule

FILE: design/gcdb_turns.sv
// Converts a signed degree value to a binary angle, rounding to nearest.
// Divides by 360 through two reciprocal multiplications by 45; five stages.
// Depends on gcdb_pkg for nothing beyond house style.
module gcdb_turns #(
  parameter int VW    = 24,
  parameter int SHIFT = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] v_in,
  output logic [31:0]          turns_out
);
  import gcdb_pkg::*;

  // The value times 2^SHIFT is a multiple of 8, so the rounding
  // (n + 180) / 360 becomes (m + 22) / 45 with m = |v| * 2^J.
  localparam int J  = SHIFT - 3;
  localparam int MW = VW;
  localparam int S1 = MW + 6;
  localparam logic [63:0] M1_FULL = (64'd1 << S1) / 64'd45;
  localparam logic [MW:0] M1 = M1_FULL[MW:0];
  localparam int W2 = J + 6;
  localparam int S2 = W2 + 6;
  localparam logic [63:0] M2_FULL = (64'd1 << S2) / 64'd45;
  localparam logic [W2:0] M2 = M2_FULL[W2:0];

  logic [MW-1:0]   mag1_r, mag2_r, a0, a3_r, a3_nxt, a4_r;
  logic            neg1_r, neg2_r, neg3_r, neg4_r;
  logic [2*MW:0]   prod2_r;
  logic [MW+6:0]   a45, r0;
  logic [5:0]      r3_r, r3_nxt;
  logic [W2-1:0]   x2, x4_r, q0, q2;
  logic [2*W2:0]   prod4_r;
  logic [W2+6:0]   q45, rr;
  logic [63:0]     q, qs;
  logic [31:0]     turns_r;

  // First quotient: |v| / 45 with one correction step.
  always_comb begin
    a0  = MW'(prod2_r >> S1);
    a45 = (MW+7)'(a0) * (MW+7)'(45);
    r0  = (MW+7)'(mag2_r) - a45;
    if (r0 >= (MW+7)'(45)) begin
      a3_nxt = a0 + MW'(1);
      r3_nxt = 6'(r0 - (MW+7)'(45));
    end else begin
      a3_nxt = a0;
      r3_nxt = 6'(r0);
    end
  end

  // Second quotient over the scaled remainder, then sign and wrap.
  always_comb begin
    x2  = (W2'(r3_r) << J) + W2'(22);
    q0  = W2'(prod4_r >> S2);
    q45 = (W2+7)'(q0) * (W2+7)'(45);
    rr  = (W2+7)'(x4_r) - q45;
    q2  = (rr >= (W2+7)'(45)) ? q0 + W2'(1) : q0;
    q   = (64'(a4_r) << J) + 64'(q2);
    qs  = neg4_r ? -q : q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= v_in[VW-1] ? MW'(-v_in) : MW'(v_in);
      neg1_r  <= v_in[VW-1];
      prod2_r <= (2*MW+1)'(mag1_r) * (2*MW+1)'(M1);
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      a3_r    <= a3_nxt;
      r3_r    <= r3_nxt;
      neg3_r  <= neg2_r;
      prod4_r <= (2*W2+1)'(x2) * (2*W2+1)'(M2);
      x4_r    <= x2;
      a4_r    <= a3_r;
      neg4_r  <= neg3_r;
      turns_r <= qs[31:0];
    end
  end

  assign turns_out = turns_r;

endmodule

FILE: design/gcdb_sincos.sv
// Pipelined rotation CORDIC giving Q30 sine and cosine of a binary angle.
// One register stage per iteration plus a fold stage and an output stage.
// Depends on gcdb_pkg for the gain, the angle table and the result width.
module gcdb_sincos #(
  parameter int STAGES = 24
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [31:0]                         ang_in,
  output logic signed [gcdb_pkg::SC_W-1:0]    sin_out,
  output logic signed [gcdb_pkg::SC_W-1:0]    cos_out
);
  import gcdb_pkg::*;

  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] QTR  = 34'sh0_4000_0000;
  localparam logic signed [ZW-1:0] HALF = 34'sh0_8000_0000;

  logic signed [ZW-1:0] x_r [STAGES+1];
  logic signed [ZW-1:0] y_r [STAGES+1];
  logic signed [ZW-1:0] z_r [STAGES+1];
  logic                 flip_r [STAGES+1];
  logic signed [ZW-1:0] z0, zf, xo, yo;
  logic                 flipf;
  logic signed [SC_W-1:0] sin_r, cos_r;

  // Fold the angle into a quarter turn either side of zero.
  always_comb begin
    z0    = {{2{ang_in[31]}}, ang_in};
    zf    = z0;
    flipf = 1'b0;
    if (z0 > QTR) begin
      zf    = z0 - HALF;
      flipf = 1'b1;
    end else if (z0 < -QTR) begin
      zf    = z0 + HALF;
      flipf = 1'b1;
    end
    xo = flip_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
    yo = flip_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
  end

  // Iteration stages; each reads only the stage before it.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= zf;
      flip_r[0] <= flipf;
      for (int i = 0; i < STAGES; i++) begin
        flip_r[i+1] <= flip_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - $signed({2'b00, ATAN_TURNS[i]});
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + $signed({2'b00, ATAN_TURNS[i]});
        end
      end
      sin_r <= yo[SC_W-1:0];
      cos_r <= xo[SC_W-1:0];
    end
  end

  assign sin_out = sin_r;
  assign cos_out = cos_r;

endmodule

FILE: design/gcdb_isqrt.sv
// Pipelined integer square root of a Q60 value, giving a Q30 floor root.
// One result bit per stage after an input register.
// Depends on gcdb_pkg for the operand and root widths.
module gcdb_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gcdb_pkg::A60_W-1:0]    n_in,
  output logic [gcdb_pkg::ROOT_W-1:0]   root_out
);
  import gcdb_pkg::*;

  localparam int NW = A60_W + 1;

  logic [NW-1:0] n_r [SQRT_STEPS+1];
  logic [NW-1:0] r_r [SQRT_STEPS+1];

  // Trial bit of step i, from 2^60 down to 1.
  function automatic logic [NW-1:0] trial_bit(int i);
    return NW'(1) << (2 * (SQRT_STEPS - 1 - i));
  endfunction

  // Restoring square root, one step per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= NW'(n_in);
      r_r[0] <= '0;
      for (int i = 0; i < SQRT_STEPS; i++) begin
        if (n_r[i] >= r_r[i] + trial_bit(i)) begin
          n_r[i+1] <= n_r[i] - (r_r[i] + trial_bit(i));
          r_r[i+1] <= (r_r[i] >> 1) + trial_bit(i);
        end else begin
          n_r[i+1] <= n_r[i];
          r_r[i+1] <= r_r[i] >> 1;
        end
      end
    end
  end

  assign root_out = r_r[SQRT_STEPS][ROOT_W-1:0];

endmodule

FILE: design/gcdb_atan2.sv
// Pipelined vectoring CORDIC giving atan2(y, x) as a binary angle.
// A pre-rotation stage, one stage per iteration and an output stage.
// Depends on gcdb_pkg for the angle table.
module gcdb_atan2 #(
  parameter int IW     = 33,
  parameter int STAGES = 24
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] y_in,
  input  logic signed [IW-1:0] x_in,
  output logic [31:0]          ang_out
);
  import gcdb_pkg::*;

  localparam int XW = IW + 2;

  logic signed [XW-1:0] x_r [STAGES+1];
  logic signed [XW-1:0] y_r [STAGES+1];
  logic [31:0]          z_r [STAGES+1];
  logic                 zero_r [STAGES+1];
  logic signed [XW-1:0] xe, ye;
  logic [31:0]          ang_r;

  assign xe = XW'(x_in);
  assign ye = XW'(y_in);

  // Pre-rotate a left half-plane vector by a half turn, then iterate.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= 32'h8000_0000;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
      for (int i = 0; i < STAGES; i++) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_TURNS[i];
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_TURNS[i];
        end
      end
      ang_r <= zero_r[STAGES] ? '0 : z_r[STAGES];
    end
  end

  assign ang_out = ang_r;

endmodule

FILE: design/great_circle_distance_bearing.sv
// Haversine distance and initial bearing from a configured home point.
// Input channel (in_*): one target position per transfer; result channel
// (out_*): one result per input transfer, in order. Home latitude and
// longitude are written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, since the block does not enforce it. The delay
// from input transfer to out_tvalid is set by the two CORDIC chains in
// series and the 31-step square root. Throughput is one item per cycle while
// the skid register is not full: every stage is a register step, so a new position enters on each such cycle.
// Reset clears the home point to zero and empties the pipeline.
// When the receiver stalls, the finished result waits in the output
// register and one more lands in a skid register; in_tready drops only
// while the skid register is full, and the whole pipeline then holds.
// Items with position_valid low give an all-zero result; a target equal
// to home gives distance_valid high with zero distance and bearing.
// Depends on gcdb_pkg and the gcdb_* submodules.
module great_circle_distance_bearing #(
  parameter int ANGLE_FRAC_BITS = gcdb_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = gcdb_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [gcdb_pkg::CFG_W-1:0]       cfg_data,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [23:0] target_latitude, [48:24] target_longitude, [55:49] zero
  input  logic [gcdb_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] position_valid
  input  logic                             in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [18:0] distance_sixteenth_km, [33:19] bearing_sixtyfourth_deg, [39:34] zero
  output logic [gcdb_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] distance_valid
  output logic                             out_tuser
);
  import gcdb_pkg::*;

  localparam int SH_FULL  = 32 - ANGLE_FRAC_BITS;
  localparam int SH_HALF  = 31 - ANGLE_FRAC_BITS;
  localparam int FLAG_DLY = 2 * CORDIC_STAGES + 45;
  localparam int BRG_DLY  = 33;
  localparam logic signed [63:0] ONE60_S = 64'sh1000_0000_0000_0000;
  localparam logic [A60_W-1:0]   ONE60   = 61'h1000_0000_0000_0000;

  // Configuration registers.
  logic signed [LAT_W-1:0] base_lat_r;
  logic signed [LON_W-1:0] base_lon_r;

  // Pipeline control.
  logic    en;
  logic    in_xfer;
  flags_t  s0_flags_r, dly_flags, e1_flags_r;
  logic    e2_vld_r;
  result_t e2_res_r, e2_res_nxt;

  // Input stage.
  logic signed [LAT_W-1:0] tlat, s0_hlat_r, s0_tlat_r;
  logic signed [LON_W-1:0] tlon;
  logic signed [LAT_W:0]   s0_dlat_r;
  logic signed [LON_W:0]   s0_dlon_r;

  // Angles and trig results.
  logic [31:0] t_hlat, t_tlat, t_dlat2, t_dlon2, t_dlon;
  logic signed [SC_W-1:0] s1, c1, s2, c2, sh_lat, sh_lon, sd, cd;

  // Haversine chain.
  logic signed [63:0] h_cc_r, h_shl2a_r, h_shl2b_r, h_shl2c_r, h_p2_r, h_p3_r, h_sum;
  logic signed [31:0] h_shlon1_r, h_shlon2_r, h_t1, h_t2;
  logic [A60_W-1:0]   h_a_r, h_b_r, h_a_nxt;
  logic [ROOT_W-1:0]  root_a, root_b;
  logic [31:0]        t_dist;

  // Bearing chain.
  logic signed [63:0] b_yp_r, b_sc_r, b_cs_r, b_tc_r, b_yp2_r, b_cs2_r, b_diff;
  logic signed [31:0] b_cd1_r, b_term;
  logic signed [32:0] b_x_r, b_y_r, b_xd, b_yd;
  logic [31:0]        t_brg;

  // Output scaling.
  logic [ROOT_W-1:0] e1_h;
  logic [62:0]       e1_dp_r;
  logic [46:0]       e1_bp_r;
  logic [63:0]       d_sum;
  logic [47:0]       b_sum;
  logic [15:0]       b_raw;

  // Output register and skid register.
  logic    out_valid_r, skid_valid_r, out_take;
  result_t out_res_r, skid_res_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign in_xfer   = in_tvalid && in_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_lat_r <= '0;
      base_lon_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HOME_LAT: base_lat_r <= cfg_data[LAT_W-1:0];
        REG_HOME_LON: base_lon_r <= cfg_data[LON_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: capture the item, the home point and the differences.
  assign tlat = in_tdata[LAT_W-1:0];
  assign tlon = in_tdata[LAT_W+LON_W-1:LAT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_flags_r <= '0;
    end else if (en) begin
      s0_flags_r.vld  <= in_xfer;
      s0_flags_r.pos  <= in_tuser;
      s0_flags_r.same <= (tlat == base_lat_r) && (tlon == base_lon_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_hlat_r <= base_lat_r;
      s0_tlat_r <= tlat;
      s0_dlat_r <= (LAT_W+1)'(tlat) - (LAT_W+1)'(base_lat_r);
      s0_dlon_r <= (LON_W+1)'(tlon) - (LON_W+1)'(base_lon_r);
    end
  end

  // Flags follow the datapath up to the output scaling stage.
  gcdb_delay #(.WIDTH($bits(flags_t)), .DEPTH(FLAG_DLY)) u_flag_dly (
    .clk, .rst_n, .en, .d_in(s0_flags_r), .d_out(dly_flags)
  );

  // Degree to binary angle conversion.
  gcdb_turns #(.VW(LAT_W), .SHIFT(SH_FULL)) u_turns_hlat (
    .clk, .en, .v_in(s0_hlat_r), .turns_out(t_hlat));
  gcdb_turns #(.VW(LAT_W), .SHIFT(SH_FULL)) u_turns_tlat (
    .clk, .en, .v_in(s0_tlat_r), .turns_out(t_tlat));
  gcdb_turns #(.VW(LAT_W+1), .SHIFT(SH_HALF)) u_turns_dlat2 (
    .clk, .en, .v_in(s0_dlat_r), .turns_out(t_dlat2));
  gcdb_turns #(.VW(LON_W+1), .SHIFT(SH_HALF)) u_turns_dlon2 (
    .clk, .en, .v_in(s0_dlon_r), .turns_out(t_dlon2));
  gcdb_turns #(.VW(LON_W+1), .SHIFT(SH_FULL)) u_turns_dlon (
    .clk, .en, .v_in(s0_dlon_r), .turns_out(t_dlon));

  // Sines and cosines.
  gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_hlat (
    .clk, .en, .ang_in(t_hlat), .sin_out(s1), .cos_out(c1));
  gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_tlat (
    .clk, .en, .ang_in(t_tlat), .sin_out(s2), .cos_out(c2));
  gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat2 (
    .clk, .en, .ang_in(t_dlat2), .sin_out(sh_lat), .cos_out());
  gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon2 (
    .clk, .en, .ang_in(t_dlon2), .sin_out(sh_lon), .cos_out());
  gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
    .clk, .en, .ang_in(t_dlon), .sin_out(sd), .cos_out(cd));

  // Haversine term a = sin^2(dlat/2) + cos1 cos2 sin^2(dlon/2), four stages.
  assign h_t1 = $signed(h_cc_r[61:30]);
  assign h_t2 = $signed(h_p2_r[61:30]);

  always_comb begin
    h_sum = h_shl2c_r + h_p3_r;
    if (h_sum < 0) begin
      h_a_nxt = '0;
    end else if (h_sum > ONE60_S) begin
      h_a_nxt = ONE60;
    end else begin
      h_a_nxt = h_sum[A60_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_cc_r     <= 64'(c1) * 64'(c2);
      h_shl2a_r  <= 64'(sh_lat) * 64'(sh_lat);
      h_shlon1_r <= sh_lon;
      h_p2_r     <= 64'(h_t1) * 64'(h_shlon1_r);
      h_shl2b_r  <= h_shl2a_r;
      h_shlon2_r <= h_shlon1_r;
      h_p3_r     <= 64'(h_t2) * 64'(h_shlon2_r);
      h_shl2c_r  <= h_shl2b_r;
      h_a_r      <= h_a_nxt;
      h_b_r      <= ONE60 - h_a_nxt;
    end
  end

  gcdb_isqrt u_sqrt_a (.clk, .en, .n_in(h_a_r), .root_out(root_a));
  gcdb_isqrt u_sqrt_b (.clk, .en, .n_in(h_b_r), .root_out(root_b));

  gcdb_atan2 #(.IW(33), .STAGES(CORDIC_STAGES)) u_atan_dist (
    .clk, .en,
    .y_in($signed({2'b00, root_a})),
    .x_in($signed({2'b00, root_b})),
    .ang_out(t_dist)
  );

  // Bearing vector: y = sin(dlon) cos2, x = cos1 sin2 - sin1 cos2 cos(dlon).
  assign b_term = $signed(b_sc_r[61:30]);
  assign b_diff = b_cs2_r - b_tc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_yp_r  <= 64'(sd) * 64'(c2);
      b_sc_r  <= 64'(s1) * 64'(c2);
      b_cs_r  <= 64'(c1) * 64'(s2);
      b_cd1_r <= cd;
      b_tc_r  <= 64'(b_term) * 64'(b_cd1_r);
      b_yp2_r <= b_yp_r;
      b_cs2_r <= b_cs_r;
      b_x_r   <= b_diff[62:30];
      b_y_r   <= b_yp2_r[62:30];
    end
  end

  // Hold the bearing vector until the square roots are ready, so both angles arrive together.
  gcdb_delay #(.WIDTH(66), .DEPTH(BRG_DLY)) u_brg_dly (
    .clk, .rst_n, .en,
    .d_in({b_y_r, b_x_r}),
    .d_out({b_yd, b_xd})
  );

  gcdb_atan2 #(.IW(33), .STAGES(CORDIC_STAGES)) u_atan_brg (
    .clk, .en, .y_in(b_yd), .x_in(b_xd), .ang_out(t_brg)
  );

  // Scale the central angle to 1/16 km and the bearing to 1/64 degree.
  always_comb begin
    if (t_dist[31]) begin
      e1_h = '0;
    end else if (t_dist[30:0] > 31'h4000_0000) begin
      e1_h = 31'h4000_0000;
    end else begin
      e1_h = t_dist[30:0];
    end
    d_sum = 64'(e1_dp_r) + (64'd1 << 42);
    b_sum = 48'(e1_bp_r) + (48'd1 << 31);
    b_raw = b_sum[47:32];
    e2_res_nxt.distance_valid = e1_flags_r.pos;
    if (!e1_flags_r.pos || e1_flags_r.same) begin
      e2_res_nxt.distance = '0;
      e2_res_nxt.bearing  = '0;
    end else begin
      e2_res_nxt.distance = d_sum[61:43];
      e2_res_nxt.bearing  = (b_raw == 16'(BEARING_FULL)) ? '0 : b_raw[BEAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_dp_r  <= 63'(e1_h) * 63'(DIST_SCALE);
      e1_bp_r  <= 47'(t_brg) * 47'(BEARING_FULL);
      e2_res_r <= e2_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_flags_r <= '0;
      e2_vld_r   <= 1'b0;
    end else if (en) begin
      e1_flags_r <= dly_flags;
      e2_vld_r   <= e1_flags_r.vld;
    end
  end

  // Output register with a skid register behind it.
  assign out_take = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= en && e2_vld_r;
      end
    end else if (en && e2_vld_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      out_res_r <= skid_valid_r ? skid_res_r : e2_res_r;
    end else if (en && e2_vld_r) begin
      skid_res_r <= e2_res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.distance_valid;
  assign out_tdata  = {(OUT_DATA_W-DIST_W-BEAR_W)'(0), out_res_r.bearing, out_res_r.distance};

`ifndef SYNTH
  // The skid register is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // The skid register fills only after the receiver refused a transfer.
  a_skid_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_tvalid && !out_tready))
    else $error("skid register filled without a stall");

  // Bearings are wrapped below a full turn.
  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DIST_W+BEAR_W-1:DIST_W] < BEARING_FULL))
    else $error("bearing out of range");

  // A result without a position carries no distance and no bearing.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("nonzero result for an invalid position");
`endif

endmodule
